@@ sv/wlc_pkg.sv @@
// Shared types and constants for the width LRU cache.
package wlc_pkg;

  localparam int KEY_W   = 64;
  localparam int WIDTH_W = 16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_UPDATE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               bypass;
    logic [WIDTH_W-1:0] measured_width;
    logic               measure_ok;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [WIDTH_W-1:0] width;
    logic               hit;
  } res_t;

endpackage

@@ sv/wlc_req_if.sv @@
// Request channel: lookup key, bypass flag and the externally measured width.
interface wlc_req_if;
  import wlc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   key;
  logic               bypass;
  logic [WIDTH_W-1:0] measured_width;
  logic               measure_ok;

  modport source (output valid, key, bypass, measured_width, measure_ok, input ready);
  modport sink   (input valid, key, bypass, measured_width, measure_ok, output ready);
endinterface

@@ sv/wlc_rsp_if.sv @@
// Response channel: resolved width and hit flag.
interface wlc_rsp_if;
  import wlc_pkg::*;

  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] width;
  logic               hit;

  modport source (output valid, width, hit, input ready);
  modport sink   (input valid, width, hit, output ready);
endinterface

@@ sv/wlc_ram.sv @@
// Generic simple dual-port RAM with registered read.
module wlc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/wlc_engine.sv @@
// Sequencer and shared key compare / rank update unit for the LRU cache.
module wlc_engine #(
  parameter int CAPACITY = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  wlc_pkg::req_t                 req,
  input  logic                          out_free,
  output logic                          idle,
  output wlc_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [$clog2(CAPACITY)-1:0]   ram_waddr,
  output logic [wlc_pkg::KEY_W+wlc_pkg::WIDTH_W+$clog2(CAPACITY)-1:0] ram_wdata,
  output logic [$clog2(CAPACITY)-1:0]   ram_raddr,
  input  logic [wlc_pkg::KEY_W+wlc_pkg::WIDTH_W+$clog2(CAPACITY)-1:0] ram_rdata
);
  import wlc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KEY_W + WIDTH_W + AW;

  state_t state, state_next;

  logic [CW-1:0]      count;
  logic [CW-1:0]      issue_idx;
  logic [CW-1:0]      upd_n;
  logic [CW-1:0]      scan_n;
  logic               chk_valid;
  logic [AW-1:0]      chk_idx;

  logic [KEY_W-1:0]   req_key;
  logic [WIDTH_W-1:0] req_mw;
  logic               req_ok;

  logic               found;
  logic               ins_mode;
  logic [AW-1:0]      hit_slot;
  logic [AW-1:0]      hit_rank;
  logic [WIDTH_W-1:0] hit_width;
  logic [AW-1:0]      lru_slot;
  logic [AW-1:0]      target;
  logic [WIDTH_W-1:0] res_width;
  logic               res_hit;

  logic               scanning;
  logic               rd_issue;
  logic               pass_end;
  logic               full;
  logic               key_eq;
  logic               age;
  logic               is_target;
  logic [KEY_W-1:0]   rd_key;
  logic [WIDTH_W-1:0] rd_width;
  logic [AW-1:0]      rd_rank;
  logic [AW-1:0]      new_rank;

  // RAM word layout: key, width, recency rank (0 = most recent)
  assign rd_key   = ram_rdata[DW-1 -: KEY_W];
  assign rd_width = ram_rdata[AW +: WIDTH_W];
  assign rd_rank  = ram_rdata[AW-1:0];

  // valid slots are always 0 .. count-1, so no per-slot valid bits
  assign scanning = (state == S_SEARCH) || (state == S_UPDATE);
  assign scan_n   = (state == S_UPDATE) ? upd_n : count;
  assign rd_issue = scanning && (issue_idx < scan_n);
  assign pass_end = scanning && !rd_issue && !chk_valid;
  assign full     = (count == CW'(CAPACITY));

  assign key_eq    = chk_valid && (rd_key == req_key);
  assign is_target = (chk_idx == target);
  assign age       = ins_mode || (rd_rank < hit_rank);
  assign new_rank  = is_target ? '0 : (age ? rd_rank + AW'(1) : rd_rank);

  assign ram_raddr = issue_idx[AW-1:0];
  assign ram_we    = (state == S_UPDATE) && chk_valid;
  assign ram_waddr = chk_idx;
  assign ram_wdata = (is_target && ins_mode) ? {req_key, req_mw, new_rank}
                                             : {rd_key, rd_width, new_rank};

  assign idle      = (state == S_IDLE);
  assign res.valid = (state == S_FINISH);
  assign res.width = res_width;
  assign res.hit   = res_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = req.bypass ? S_FINISH : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (pass_end) begin
          state_next = (found || req_ok) ? S_UPDATE : S_FINISH;
        end
      end
      S_UPDATE: begin
        if (pass_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      chk_valid <= 1'b0;
      found     <= 1'b0;
      issue_idx <= '0;
    end else begin
      chk_valid <= rd_issue;

      if (start && idle) begin
        req_key   <= req.key;
        req_mw    <= req.measured_width;
        req_ok    <= req.measure_ok;
        found     <= 1'b0;
        issue_idx <= '0;
        res_width <= '0;
        res_hit   <= 1'b0;
      end

      if (rd_issue) begin
        issue_idx <= issue_idx + CW'(1);
        chk_idx   <= issue_idx[AW-1:0];
      end

      if (state == S_SEARCH && key_eq) begin
        found     <= 1'b1;
        hit_slot  <= chk_idx;
        hit_rank  <= rd_rank;
        hit_width <= rd_width;
      end

      if (state == S_SEARCH && chk_valid && rd_rank == AW'(CAPACITY - 1)) begin
        lru_slot <= chk_idx;
      end

      if (state == S_SEARCH && pass_end) begin
        issue_idx <= '0;
        if (found) begin
          ins_mode  <= 1'b0;
          target    <= hit_slot;
          upd_n     <= count;
          res_width <= hit_width;
          res_hit   <= 1'b1;
        end else if (req_ok) begin
          ins_mode  <= 1'b1;
          res_width <= req_mw;
          res_hit   <= 1'b0;
          if (full) begin
            target <= lru_slot;
            upd_n  <= count;
          end else begin
            // free slot is the first one past the filled range
            target <= count[AW-1:0];
            upd_n  <= count + CW'(1);
            count  <= count + CW'(1);
          end
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && rd_issue) |-> (ram_raddr != ram_waddr))
    else $error("read and write-back hit the same slot");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && !out_free) |=>
      (state == S_FINISH && $stable(res_width) && $stable(res_hit)))
    else $error("result changed while waiting");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && pass_end && !found && req_ok && !full) |=>
      (count == $past(count) + CW'(1)))
    else $error("insert into free slot did not grow occupancy");

endmodule

@@ sv/width_lru_cache.sv @@
// Width LRU cache top level: request/response channels, engine, entry RAM.
//
// Fully associative cache of 64-bit keys to 16-bit widths, LRU replacement.
// req channel (valid/ready): key, bypass, measured_width, measure_ok.
// rsp channel (valid/ready): width, hit. Exactly one response per request.
// A request is taken only while the engine is idle; ready drops for the
// whole lookup. Entries live in one RAM (key, width, rank), visited one slot
// per cycle by a shared compare and rank-update unit.
// A bypass goes straight to the response; a failed miss (no hit, measure_ok
// low) makes a search pass over the occupied slots only; a hit or an insert
// makes the search pass, then a read-modify-write pass over the ranks. Ready
// returns once the response has been loaded into the output register.
// The response sits in an output register; a stalled receiver holds it there
// and the next request may still be accepted and worked on, finishing into
// the register once it has been taken.
// Reset (synchronous, active high) empties the cache by clearing the fill
// count; no RAM sweep is needed, so requests are taken right after reset.
module width_lru_cache #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst,
  wlc_req_if.sink        req,
  wlc_rsp_if.source      rsp
);
  import wlc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int DW = KEY_W + WIDTH_W + AW;

  req_t          req_data;
  res_t          res;
  logic          idle;
  logic          start;
  logic          out_free;
  logic          load;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_wdata;
  logic [DW-1:0] ram_rdata;

  assign req_data.key            = req.key;
  assign req_data.bypass         = req.bypass;
  assign req_data.measured_width = req.measured_width;
  assign req_data.measure_ok     = req.measure_ok;

  assign req.ready = idle;
  assign start     = req.valid && idle;
  assign out_free  = !rsp.valid || rsp.ready;
  assign load      = res.valid && out_free;

  wlc_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (req_data),
    .out_free  (out_free),
    .idle      (idle),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  wlc_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.width <= res.width;
      rsp.hit   <= res.hit;
    end
  end

endmodule
